### sv/hed_pkg.sv
// ----------------------------------------------------------------------------
// hed_pkg
// Constants and entity table for the HTML character entity decoder.
// ----------------------------------------------------------------------------
package hed_pkg;

  localparam int HOLD_MAX  = 5;   // longest held prefix
  localparam int ENT_MAX   = 6;   // longest entity string
  localparam int ENT_COUNT = 22;
  localparam int CNT_W     = 3;   // holds 0..ENT_MAX

  localparam logic [7:0] CHAR_AMP = 8'h26;

  typedef struct packed {
    logic [0:ENT_MAX-1][7:0] text;  // byte 0 first, zero padded
    logic [CNT_W-1:0]        len;
    logic [7:0]              value;
  } ent_t;

  localparam ent_t ENT_TABLE [ENT_COUNT] = '{
    '{text: {"&amp;", 8'h00},  len: 3'd5, value: 8'h26},
    '{text: {"&lt;", 16'h00},  len: 3'd4, value: 8'h3c},
    '{text: {"&gt;", 16'h00},  len: 3'd4, value: 8'h3e},
    '{text: "&quot;",          len: 3'd6, value: 8'h22},
    '{text: "&apos;",          len: 3'd6, value: 8'h27},
    '{text: "&nbsp;",          len: 3'd6, value: 8'h20},
    '{text: {"&#38;", 8'h00},  len: 3'd5, value: 8'h26},
    '{text: {"&#60;", 8'h00},  len: 3'd5, value: 8'h3c},
    '{text: {"&#62;", 8'h00},  len: 3'd5, value: 8'h3e},
    '{text: {"&#34;", 8'h00},  len: 3'd5, value: 8'h22},
    '{text: {"&#39;", 8'h00},  len: 3'd5, value: 8'h27},
    '{text: "&#160;",          len: 3'd6, value: 8'h20},
    '{text: {"&#35;", 8'h00},  len: 3'd5, value: 8'h23},
    '{text: {"&#37;", 8'h00},  len: 3'd5, value: 8'h25},
    '{text: {"&#43;", 8'h00},  len: 3'd5, value: 8'h2b},
    '{text: {"&#61;", 8'h00},  len: 3'd5, value: 8'h3d},
    '{text: {"&#64;", 8'h00},  len: 3'd5, value: 8'h40},
    '{text: {"&#91;", 8'h00},  len: 3'd5, value: 8'h5b},
    '{text: {"&#93;", 8'h00},  len: 3'd5, value: 8'h5d},
    '{text: "&#123;",          len: 3'd6, value: 8'h7b},
    '{text: "&#125;",          len: 3'd6, value: 8'h7d},
    '{text: "&#126;",          len: 3'd6, value: 8'h7e}
  };

endpackage

### sv/html_entity_decoder.sv
// ----------------------------------------------------------------------------
// html_entity_decoder
// The first result of a beat is registered and appears in the cycle after it is accepted.
// Throughput: one input beat per cycle while each beat yields at most one
// result and out_stall is low; a beat with more results holds the input
// until the multi-byte result buffer has drained its burst.
// Reset (rst_n, synchronous): nothing pending, result buffer empty.
// Streaming decoder: held entity prefix matched against a fixed table.
// ----------------------------------------------------------------------------
module html_entity_decoder
  import hed_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_msg_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_end,
  output logic       out_message_end
);

  logic [7:0]       pend_r   [HOLD_MAX];
  logic [7:0]       pend_nxt [HOLD_MAX];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [7:0]       ob_r   [ENT_MAX];
  logic [7:0]       ob_nxt [ENT_MAX];
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] hd_r, hd_nxt;
  logic             msg_r, msg_nxt;

  logic [CNT_W-1:0] c;
  logic [CNT_W-1:0] cand_len;
  logic [7:0]       cand [ENT_MAX];
  logic             whole, pre, ok, extend, restart;
  logic [7:0]       val;
  logic [CNT_W-1:0] burst_n;
  logic             in_fire, out_fire;

  assign out_valid       = (hd_r != n_r);
  assign out_run_end     = out_valid && (hd_r == n_r - 3'd1);
  assign out_message_end = out_run_end && msg_r;
  assign out_fire        = out_valid && !out_stall;
  // take a new beat once the burst in the buffer is gone or leaving now
  assign in_stall        = out_valid && !(out_run_end && !out_stall);
  assign in_fire         = in_valid && !in_stall;

  always_comb begin
    out_byte = ob_r[0];
    for (int i = 1; i < ENT_MAX; i++) begin
      if (hd_r == CNT_W'(i)) out_byte = ob_r[i];
    end
  end

  // candidate = held prefix followed by the new byte
  always_comb begin
    c        = (cnt_r > CNT_W'(HOLD_MAX)) ? CNT_W'(HOLD_MAX) : cnt_r;
    cand_len = c + 3'd1;
    for (int i = 0; i < ENT_MAX; i++) begin
      if (CNT_W'(i) < c && i < HOLD_MAX) cand[i] = pend_r[i % HOLD_MAX];
      else if (CNT_W'(i) == c)           cand[i] = in_byte;
      else                               cand[i] = 8'h00;
    end
  end

  always_comb begin
    whole = 1'b0;
    pre   = 1'b0;
    val   = 8'h00;
    ok    = 1'b0;
    for (int e = 0; e < ENT_COUNT; e++) begin
      ok = (ENT_TABLE[e].len >= cand_len);
      for (int i = 0; i < ENT_MAX; i++) begin
        if (CNT_W'(i) < cand_len && ENT_TABLE[e].text[i] != cand[i]) ok = 1'b0;
      end
      if (ok) begin
        if (ENT_TABLE[e].len == cand_len) begin
          whole = 1'b1;
          val   = ENT_TABLE[e].value;
        end else begin
          pre = 1'b1;
        end
      end
    end
  end

  always_comb begin
    extend   = !whole && pre && (c < CNT_W'(HOLD_MAX));
    restart  = !whole && !extend && (in_byte == CHAR_AMP) && !in_msg_last;
    pend_nxt = pend_r;
    for (int i = 0; i < ENT_MAX; i++) begin
      ob_nxt[i] = whole ? ((i == 0) ? val : 8'h00) : cand[i];
    end
    if (whole) begin
      burst_n = 3'd1;
      cnt_nxt = '0;
    end else if (extend) begin
      for (int i = 0; i < HOLD_MAX; i++) begin
        if (c == CNT_W'(i)) pend_nxt[i] = in_byte;
      end
      burst_n = in_msg_last ? cand_len : 3'd0;
      cnt_nxt = in_msg_last ? 3'd0 : cand_len;
    end else if (restart) begin
      // broken prefix, '&' starts a fresh one
      pend_nxt[0] = in_byte;
      burst_n     = c;
      cnt_nxt     = 3'd1;
    end else begin
      burst_n = cand_len;
      cnt_nxt = '0;
    end
  end

  always_comb begin
    n_nxt   = n_r;
    hd_nxt  = hd_r;
    msg_nxt = msg_r;
    if (in_fire) begin
      n_nxt   = burst_n;
      hd_nxt  = '0;
      msg_nxt = in_msg_last;
    end else if (out_fire) begin
      hd_nxt = hd_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      n_r   <= '0;
      hd_r  <= '0;
    end else begin
      if (in_fire) cnt_r <= cnt_nxt;
      n_r  <= n_nxt;
      hd_r <= hd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    msg_r <= msg_nxt;
    if (in_fire) begin
      pend_r <= pend_nxt;
      ob_r   <= ob_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_head_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    hd_r <= n_r)
    else $error("burst head past burst length");

  a_hold_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(HOLD_MAX))
    else $error("held prefix too long");

  a_last_flushes: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_msg_last |=> cnt_r == '0)
    else $error("prefix left held after end of message");

  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_msg_last |=> out_valid)
    else $error("end-of-message beat gave no result");
`endif

endmodule

### tb/html_entity_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// html_entity_decoder_tb
// Drives text messages through the entity decoder and checks every decoded
// byte, with its run and message end flags, against an in-bench model of the
// prefix-holding decoder. A directed script comes first, then random messages
// built from entities, cut-off prefixes, stray '&' and arbitrary bytes, under
// three idling patterns on the input and output sides.
// ----------------------------------------------------------------------------
module html_entity_decoder_tb;
  import hed_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       typed;   // want holds the single expected byte of this beat
    logic [7:0] want;
  } text_beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       msg_end;
  } dec_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_msg_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_run_end;
  logic       out_message_end;

  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int err_count    = 0;

  string      ent_str [ENT_COUNT] = '{
    "&amp;", "&lt;", "&gt;", "&quot;", "&apos;", "&nbsp;",
    "&#38;", "&#60;", "&#62;", "&#34;", "&#39;", "&#160;",
    "&#35;", "&#37;", "&#43;", "&#61;", "&#64;", "&#91;",
    "&#93;", "&#123;", "&#125;", "&#126;"
  };
  logic [7:0] ent_chr [ENT_COUNT] = '{
    8'h26, 8'h3c, 8'h3e, 8'h22, 8'h27, 8'h20,
    8'h26, 8'h3c, 8'h3e, 8'h22, 8'h27, 8'h20,
    8'h23, 8'h25, 8'h2b, 8'h3d, 8'h40, 8'h5b,
    8'h5d, 8'h7b, 8'h7d, 8'h7e
  };

  // directed script: extremes, entities of lengths 5 and 6, the longest hold broken
  // by plain text, a stray '&', and prefixes cut off by the message end
  text_beat_t script [25] = '{
    '{8'h00, 1'b0, 1'b1, 8'h00},
    '{8'hff, 1'b1, 1'b1, 8'hff},
    '{"&",   1'b0, 1'b0, 8'h00},
    '{"a",   1'b0, 1'b0, 8'h00},
    '{"m",   1'b0, 1'b0, 8'h00},
    '{"p",   1'b0, 1'b0, 8'h00},
    '{";",   1'b0, 1'b1, 8'h26},
    '{"&",   1'b0, 1'b0, 8'h00},
    '{"n",   1'b0, 1'b0, 8'h00},
    '{"b",   1'b0, 1'b0, 8'h00},
    '{"s",   1'b0, 1'b0, 8'h00},
    '{"p",   1'b0, 1'b0, 8'h00},
    '{";",   1'b0, 1'b1, 8'h20},
    '{"&",   1'b0, 1'b0, 8'h00},
    '{"#",   1'b0, 1'b0, 8'h00},
    '{"1",   1'b0, 1'b0, 8'h00},
    '{"2",   1'b0, 1'b0, 8'h00},
    '{"6",   1'b0, 1'b0, 8'h00},
    '{"x",   1'b0, 1'b0, 8'h00},
    '{"&",   1'b0, 1'b0, 8'h00},
    '{"q",   1'b0, 1'b0, 8'h00},
    '{"&",   1'b0, 1'b0, 8'h00},
    '{"g",   1'b0, 1'b0, 8'h00},
    '{"t",   1'b1, 1'b0, 8'h00},
    '{"&",   1'b1, 1'b1, 8'h26}
  };

  // decoder model state
  logic [7:0] amp_prefix [HOLD_MAX];
  int         prefix_len = 0;
  logic [7:0] burst_q [$];      // bytes produced by the latest input beat

  text_beat_t sent_q [$];       // beats on the input port, oldest first
  dec_beat_t  decoded_q [$];    // expected output beats
  text_beat_t stim_q [$];

  html_entity_decoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_msg_last     (in_msg_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_run_end     (out_run_end),
    .out_message_end (out_message_end)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // 2: whole entity (char in ch), 1: proper prefix of one, 0: neither
  function automatic int match_entity(input logic [0:ENT_MAX-1][7:0] cand, input int len,
                                      output logic [7:0] ch);
    int  found;
    bit  same;
    found = 0;
    ch    = 8'h00;
    for (int e = 0; e < ENT_COUNT; e++) begin
      if (ent_str[e].len() < len) continue;
      same = 1'b1;
      for (int k = 0; k < len; k++)
        if (ent_str[e][k] != cand[k]) same = 1'b0;
      if (!same) continue;
      if (ent_str[e].len() == len) begin
        ch = ent_chr[e];
        return 2;
      end
      found = 1;
    end
    return found;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic last);
    logic [0:ENT_MAX-1][7:0] cand;
    logic [7:0]              ch;
    int                      m;
    burst_q.delete();
    if (prefix_len == 0) begin
      if (b == CHAR_AMP) begin
        amp_prefix[0] = b;
        prefix_len = 1;
      end else begin
        burst_q.insert(burst_q.size(), b);
      end
    end else begin
      cand = '0;
      for (int k = 0; k < prefix_len; k++) cand[k] = amp_prefix[k];
      cand[prefix_len] = b;
      m = match_entity(cand, prefix_len + 1, ch);
      if (m == 2) begin
        burst_q.insert(burst_q.size(), ch);
        prefix_len = 0;
      end else if (m == 1 && prefix_len < HOLD_MAX) begin
        amp_prefix[prefix_len] = b;
        prefix_len++;
      end else begin
        // broken prefix: release it as plain text
        for (int k = 0; k < prefix_len; k++) burst_q.insert(burst_q.size(), amp_prefix[k]);
        if (b == CHAR_AMP) begin
          amp_prefix[0] = b;
          prefix_len = 1;
        end else begin
          burst_q.insert(burst_q.size(), b);
          prefix_len = 0;
        end
      end
    end
    if (last) begin
      for (int k = 0; k < prefix_len; k++) burst_q.insert(burst_q.size(), amp_prefix[k]);
      prefix_len = 0;
    end
  endfunction

  // a message of a few tokens: whole entities half the time, otherwise cut-off
  // prefixes, arbitrary bytes and stray '&'
  function automatic void add_message();
    int         toks;
    int         kind;
    int         e;
    int         cut;
    text_beat_t t;
    toks = $urandom_range(1, 6);
    t.last  = 1'b0;
    t.typed = 1'b0;
    t.want  = 8'h00;
    for (int i = 0; i < toks; i++) begin
      kind = $urandom_range(0, 99);
      e    = $urandom_range(0, ENT_COUNT - 1);
      if (kind < 65) begin
        cut = (kind < 50) ? ent_str[e].len() : $urandom_range(1, ent_str[e].len() - 1);
        for (int k = 0; k < cut; k++) begin
          t.data = ent_str[e][k];
          stim_q.insert(stim_q.size(), t);
        end
      end else if (kind < 90) begin
        t.data = 8'($urandom_range(0, 255));
        stim_q.insert(stim_q.size(), t);
      end else begin
        t.data = CHAR_AMP;
        stim_q.insert(stim_q.size(), t);
      end
    end
    stim_q[stim_q.size() - 1].last = 1'b1;
  endfunction

  task automatic send_beat(input text_beat_t t);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    sent_q.insert(sent_q.size(), t);
    in_valid    <= 1'b1;
    in_byte     <= t.data;
    in_msg_last <= t.last;
    do @(posedge clk); while (in_stall);
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < out_idle_pct);
  end

  // input acceptance feeds the model, output acceptance is checked
  always @(posedge clk) begin : scoreboard
    text_beat_t acc;
    dec_beat_t  exp_beat;
    dec_beat_t  queued;
    int         n;
    if (rst_n && in_valid && !in_stall) begin
      acc = sent_q.pop_front();
      decode_byte(in_byte, in_msg_last);
      if (acc.typed) begin
        queued = '{acc.want, 1'b1, in_msg_last};
        decoded_q.insert(decoded_q.size(), queued);
      end else begin
        n = burst_q.size();
        for (int i = 0; i < n; i++) begin
          queued = '{burst_q[i], i == n - 1, in_msg_last && i == n - 1};
          decoded_q.insert(decoded_q.size(), queued);
        end
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected output beat: out_byte %h", out_byte);
        err_count++;
      end else begin
        exp_beat = decoded_q.pop_front();
        if (out_byte !== exp_beat.data) begin
          $error("out_byte: expected %h, got %h", exp_beat.data, out_byte);
          err_count++;
        end
        if (out_run_end !== exp_beat.run_end) begin
          $error("out_run_end: expected %b, got %b", exp_beat.run_end, out_run_end);
          err_count++;
        end
        if (out_message_end !== exp_beat.msg_end) begin
          $error("out_message_end: expected %b, got %b", exp_beat.msg_end, out_message_end);
          err_count++;
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    in_idle_pct  = 20;
    out_idle_pct = 53;
    foreach (script[i]) send_beat(script[i]);

    for (int phase = 0; phase < 3; phase++) begin
      in_idle_pct  = (phase == 0) ? 20 : (phase == 1) ? 53 : 0;
      out_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 20 : 0;
      stim_q.delete();
      while (stim_q.size() < 117) add_message();
      foreach (stim_q[i]) send_beat(stim_q[i]);
    end
    in_valid <= 1'b0;

    while (decoded_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0)
      $display("html_entity_decoder_tb: clean");
    else
      $display("html_entity_decoder_tb: errors");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("html_entity_decoder_tb: errors");
    $finish;
  end

endmodule

### sim.f
sv/hed_pkg.sv
sv/html_entity_decoder.sv
tb/html_entity_decoder_tb.sv
